FILE: src/blist_pkg.sv
// Shared types and constants for the bounded positional list.
`timescale 1ns / 1ps

package blist_pkg;

  // List geometry
  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;

  // Command codes
  localparam logic [2:0] CMD_INS_HEAD = 3'd0;
  localparam logic [2:0] CMD_INS_TAIL = 3'd1;
  localparam logic [2:0] CMD_INS_POS  = 3'd2;
  localparam logic [2:0] CMD_DEL_HEAD = 3'd3;
  localparam logic [2:0] CMD_DEL_TAIL = 3'd4;
  localparam logic [2:0] CMD_DEL_POS  = 3'd5;

  // Status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_RANGE = 2'd2;
  localparam logic [1:0] STAT_FULL  = 2'd3;

  // Input request
  typedef struct packed {
    logic [2:0]         cmd;
    logic signed [31:0] value;
    logic [4:0]         position;
  } req_t;

  // Result
  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] removed_value;
    logic [4:0]         entry_count;
  } res_t;

  // Entry memory access from the sequencer
  typedef struct packed {
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [DATA_W-1:0] wr_data;
  } mem_req_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_SHIFT,
    S_INS_PUT,
    S_DEL_GRAB,
    S_DEL_SHIFT,
    S_DONE
  } state_t;

endpackage

FILE: src/blist_ram.sv
// Entry store: one write port, one read port, registered read data.
`timescale 1ns / 1ps

module blist_ram (
  input  logic                                 clk,
  input  blist_pkg::mem_req_t                  mreq,
  output logic [blist_pkg::DATA_W-1:0]         rd_data
);
  import blist_pkg::*;

  logic [DATA_W-1:0] mem [CAPACITY];

  // Write port
  always_ff @(posedge clk) begin
    if (mreq.wr_en) begin
      mem[mreq.wr_addr] <= mreq.wr_data;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk) begin
    if (mreq.rd_en) begin
      rd_data <= mem[mreq.rd_addr];
    end
  end

endmodule

FILE: src/blist_ctrl.sv
// Command decode and shift sequencer over the entry memory.
`timescale 1ns / 1ps

module blist_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         req_valid,
  input  blist_pkg::req_t              req,
  output logic                         req_stall,
  output blist_pkg::mem_req_t          mreq,
  input  logic [blist_pkg::DATA_W-1:0] rd_data,
  output logic                         done_valid,
  output blist_pkg::res_t              done,
  input  logic                         done_take
);
  import blist_pkg::*;

  state_t            state, state_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [CNT_W-1:0]  idx, idx_next;
  logic [CNT_W-1:0]  pos, pos_next;
  logic [DATA_W-1:0] val, val_next;
  logic              wr_pend, wr_pend_next;
  logic [IDX_W-1:0]  wr_addr, wr_addr_next;
  logic [1:0]        status, status_next;
  logic [DATA_W-1:0] removed, removed_next;

  logic              accept;
  logic              dec_known;
  logic              dec_is_ins;
  logic [CNT_W-1:0]  dec_pos;
  logic [1:0]        dec_status;
  logic              dec_go;
  logic [CNT_W-1:0]  idx_up;

  assign accept = req_valid && !req_stall;
  assign idx_up = idx + CNT_W'(1);

  // Decode target position and status of the incoming command
  always_comb begin
    dec_known  = 1'b1;
    dec_is_ins = 1'b0;
    dec_pos    = '0;
    case (req.cmd)
      CMD_INS_HEAD: begin
        dec_is_ins = 1'b1;
      end
      CMD_INS_TAIL: begin
        dec_is_ins = 1'b1;
        dec_pos    = count;
      end
      CMD_INS_POS: begin
        dec_is_ins = 1'b1;
        dec_pos    = CNT_W'(req.position);
      end
      CMD_DEL_HEAD: begin
        dec_pos = '0;
      end
      CMD_DEL_TAIL: begin
        dec_pos = (count == '0) ? '0 : count - CNT_W'(1);
      end
      CMD_DEL_POS: begin
        dec_pos = CNT_W'(req.position);
      end
      default: begin
        dec_known = 1'b0;
      end
    endcase

    dec_status = STAT_OK;
    if (dec_known) begin
      if (dec_is_ins) begin
        if (req.position > 5'(count) && req.cmd == CMD_INS_POS) begin
          dec_status = STAT_RANGE;
        end else if (count >= CNT_W'(CAPACITY)) begin
          dec_status = STAT_FULL;
        end
      end else begin
        if (count == '0) begin
          dec_status = STAT_EMPTY;
        end else if (req.cmd == CMD_DEL_POS && req.position >= 5'(count)) begin
          dec_status = STAT_RANGE;
        end
      end
    end
    dec_go = dec_known && (dec_status == STAT_OK);
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (!dec_go) begin
            state_next = S_DONE;
          end else if (dec_is_ins) begin
            state_next = S_INS_SHIFT;
          end else begin
            state_next = S_DEL_GRAB;
          end
        end
      end
      S_INS_SHIFT: begin
        if (idx <= pos) begin
          state_next = S_INS_PUT;
        end
      end
      S_INS_PUT: begin
        state_next = S_DONE;
      end
      S_DEL_GRAB: begin
        state_next = S_DEL_SHIFT;
      end
      S_DEL_SHIFT: begin
        if (idx_up >= count) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (done_take) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Outputs, memory accesses and datapath updates
  always_comb begin
    count_next   = count;
    idx_next     = idx;
    pos_next     = pos;
    val_next     = val;
    wr_pend_next = wr_pend;
    wr_addr_next = wr_addr;
    status_next  = status;
    removed_next = removed;
    mreq         = '0;
    req_stall    = (state != S_IDLE);
    done_valid   = (state == S_DONE);

    case (state)
      S_IDLE: begin
        if (accept) begin
          idx_next     = dec_is_ins ? count : dec_pos;
          pos_next     = dec_pos;
          val_next     = req.value;
          status_next  = dec_status;
          removed_next = '0;
          wr_pend_next = 1'b0;
          // deletes fetch the removed entry right away
          if (dec_go && !dec_is_ins) begin
            mreq.rd_en   = 1'b1;
            mreq.rd_addr = dec_pos[IDX_W-1:0];
          end
        end
      end
      S_INS_SHIFT: begin
        // move entries one slot toward the tail, highest first
        if (wr_pend) begin
          mreq.wr_en   = 1'b1;
          mreq.wr_addr = wr_addr;
          mreq.wr_data = rd_data;
        end
        if (idx > pos) begin
          mreq.rd_en   = 1'b1;
          mreq.rd_addr = IDX_W'(idx - CNT_W'(1));
          wr_pend_next = 1'b1;
          wr_addr_next = idx[IDX_W-1:0];
          idx_next     = idx - CNT_W'(1);
        end else begin
          wr_pend_next = 1'b0;
        end
      end
      S_INS_PUT: begin
        mreq.wr_en   = 1'b1;
        mreq.wr_addr = pos[IDX_W-1:0];
        mreq.wr_data = val;
        count_next   = count + CNT_W'(1);
      end
      S_DEL_GRAB: begin
        removed_next = rd_data;
      end
      S_DEL_SHIFT: begin
        // move entries one slot toward the head, lowest first
        if (wr_pend) begin
          mreq.wr_en   = 1'b1;
          mreq.wr_addr = wr_addr;
          mreq.wr_data = rd_data;
        end
        if (idx_up < count) begin
          mreq.rd_en   = 1'b1;
          mreq.rd_addr = idx_up[IDX_W-1:0];
          wr_pend_next = 1'b1;
          wr_addr_next = idx[IDX_W-1:0];
          idx_next     = idx_up;
        end else begin
          wr_pend_next = 1'b0;
          count_next   = count - CNT_W'(1);
        end
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase

    done.status        = status;
    done.removed_value = removed;
    done.entry_count   = 5'(count);
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      count   <= '0;
      wr_pend <= 1'b0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      wr_pend <= wr_pend_next;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    idx     <= idx_next;
    pos     <= pos_next;
    val     <= val_next;
    wr_addr <= wr_addr_next;
    status  <= status_next;
    removed <= removed_next;
  end

endmodule

FILE: src/bounded_positional_list.sv
// Top level of the bounded positional list: sequencer, entry memory, result register.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid, req_stall | req (cmd, value, position)
//   res     | out       | res_valid, res_stall | res (status, removed_value, entry_count)
//
// One request at a time. An insert or delete at position p moves the part of
// the list from p to the tail by one slot, and the entry memory moves one
// entry per cycle over its single write port. The result register lets the
// next request in while a result still waits. rst clears count to zero;
// the memory needs no clearing since only entries below count are read.
`timescale 1ns / 1ps

module bounded_positional_list (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  input  blist_pkg::req_t req,
  output logic            req_stall,
  output logic            res_valid,
  output blist_pkg::res_t res,
  input  logic            res_stall
);
  import blist_pkg::*;

  mem_req_t          mreq;
  logic [DATA_W-1:0] rd_data;
  logic              done_valid;
  res_t              done;
  logic              done_take;

  blist_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req        (req),
    .req_stall  (req_stall),
    .mreq       (mreq),
    .rd_data    (rd_data),
    .done_valid (done_valid),
    .done       (done),
    .done_take  (done_take)
  );

  blist_ram u_ram (
    .clk     (clk),
    .mreq    (mreq),
    .rd_data (rd_data)
  );

  // Result register
  assign done_take = done_valid && (!res_valid || !res_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (done_take) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done_take) begin
      res <= done;
    end
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res.entry_count <= 5'(CAPACITY)))
    else $error("entry count above capacity");

  a_fail_no_value: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.status != STAT_OK) |-> (res.removed_value == '0))
    else $error("removed value on a failed command");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    (mreq.wr_en && mreq.rd_en) |-> (mreq.wr_addr != mreq.rd_addr))
    else $error("read and write of the same entry in one cycle");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> req_stall)
    else $error("request taken while another is in progress");

endmodule

FILE: verif/blist_checker.sv
// Checker for the bounded positional list: predicts each result from the accepted requests.
`timescale 1ns / 1ps

module blist_checker (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  input  blist_pkg::req_t req,
  input  logic            req_stall,
  input  logic            res_valid,
  input  blist_pkg::res_t res,
  input  logic            res_stall,
  output int              failures,
  output int              pending,
  output int              level
);
  import blist_pkg::*;

  // Predicted list contents and occupancy
  logic signed [DATA_W-1:0] cells [CAPACITY];
  int unsigned              held;
  res_t                     awaited_results [$];
  int                       mismatch_count = 0;
  int unsigned              result_no = 0;

  assign failures = mismatch_count;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("MISMATCH result %0d %s: got %0h, expected %0h (t=%0t)",
             result_no, what, got, want, $realtime);
    mismatch_count++;
  endtask

  // Apply one command to the predicted list and return the result it gives
  function automatic res_t apply_command(input req_t r);
    res_t        o;
    int unsigned p;
    int          i;
    o = '0;
    o.status = STAT_OK;
    case (r.cmd)
      CMD_INS_HEAD, CMD_INS_TAIL, CMD_INS_POS: begin
        if (r.cmd == CMD_INS_HEAD) p = 0;
        else if (r.cmd == CMD_INS_TAIL) p = held;
        else p = 32'(r.position);
        // range check wins over the full check
        if (p > held) begin
          o.status = STAT_RANGE;
        end else if (held >= CAPACITY) begin
          o.status = STAT_FULL;
        end else begin
          for (i = int'(held); i > int'(p); i--) cells[i] = cells[i-1];
          cells[p] = r.value;
          held++;
        end
      end
      CMD_DEL_HEAD, CMD_DEL_TAIL, CMD_DEL_POS: begin
        if (r.cmd == CMD_DEL_HEAD) p = 0;
        else if (r.cmd == CMD_DEL_TAIL) p = (held == 0) ? 0 : held - 1;
        else p = 32'(r.position);
        if (held == 0) begin
          o.status = STAT_EMPTY;
        end else if (p >= held) begin
          o.status = STAT_RANGE;
        end else begin
          o.removed_value = cells[p];
          for (i = int'(p); i + 1 < int'(held); i++) cells[i] = cells[i+1];
          held--;
        end
      end
      default: ; // unused codes leave the list alone
    endcase
    o.entry_count = held[4:0];
    return o;
  endfunction

  // Watch both channels; results are checked before the same-edge request is queued
  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      held = 0;
      awaited_results.delete();
    end else begin
      if (res_valid && !res_stall) begin
        result_no++;
        if (awaited_results.size() == 0) begin
          report("arrived with no request waiting", res.removed_value, 32'h0);
        end else begin
          want = awaited_results.pop_front();
          if (res.status !== want.status)
            report("status", 32'(res.status), 32'(want.status));
          if (res.removed_value !== want.removed_value)
            report("removed_value", res.removed_value, want.removed_value);
          if (res.entry_count !== want.entry_count)
            report("entry_count", 32'(res.entry_count), 32'(want.entry_count));
        end
      end
      if (req_valid && !req_stall)
        awaited_results.push_back(apply_command(req));
    end
    pending <= awaited_results.size();
    level   <= int'(held);
  end

endmodule

FILE: verif/bounded_positional_list_tb.sv
// Testbench top for the bounded positional list: clock, reset, requests, result stalls, verdict.
`timescale 1ns / 1ps

module bounded_positional_list_tb;
  import blist_pkg::*;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  req_t req       = '0;
  logic res_stall = 1'b0;
  logic hold_ask  = 1'b0;
  logic req_stall;
  logic res_valid;
  res_t res;

  int          failures;
  int          pending;
  int          level;
  int unsigned list_cmds = 0;

  always #6 clk = ~clk;

  bounded_positional_list dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req       (req),
    .req_stall (req_stall),
    .res_valid (res_valid),
    .res       (res),
    .res_stall (res_stall)
  );

  blist_checker chk (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req       (req),
    .req_stall (req_stall),
    .res_valid (res_valid),
    .res       (res),
    .res_stall (res_stall),
    .failures  (failures),
    .pending   (pending),
    .level     (level)
  );

  // Hard stop in case the block hangs
  initial begin
    #3000000;
    $display("Timeout: block stopped answering");
    $display("Simulation FAILED");
    $finish;
  end

  function automatic req_t mk(input logic [2:0] cmd, input logic [31:0] value, input int pos);
    req_t r;
    r.cmd      = cmd;
    r.value    = value;
    r.position = 5'(pos);
    return r;
  endfunction

  // Mostly random values, with the extremes mixed in
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Random command biased toward legal positions for the current fill level
  function automatic req_t random_cmd(input int ins_pct);
    req_t r;
    int   roll;
    r = mk(CMD_INS_HEAD, pick_value(), $urandom_range(0, 31));
    roll = $urandom_range(0, 99);
    if (roll < 3) begin
      r.cmd = 3'($urandom_range(6, 7));
    end else if (roll < 3 + ins_pct) begin
      r.cmd = 3'($urandom_range(CMD_INS_HEAD, CMD_INS_POS));
      if (r.cmd == CMD_INS_POS && $urandom_range(0, 99) < 85)
        r.position = 5'($urandom_range(0, level));
    end else begin
      r.cmd = 3'($urandom_range(CMD_DEL_HEAD, CMD_DEL_POS));
      if (r.cmd == CMD_DEL_POS && $urandom_range(0, 99) < 85)
        r.position = 5'((level > 0) ? $urandom_range(0, level - 1) : 0);
    end
    return r;
  endfunction

  // Offer one request and hold it until accepted
  task automatic send(input req_t r);
    req_valid <= 1'b1;
    req       <= r;
    do @(posedge clk); while (req_stall);
  endtask

  task automatic idle(input int n);
    if (n > 0) begin
      req_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Stop sending until every predicted result has come back
  task automatic drain();
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Result side: segments of free flow, light and heavy stalling, plus a long hold-off on request
  initial begin : result_side
    int seg;
    int mode;
    int i;
    forever begin
      if (hold_ask) begin
        hold_ask <= 1'b0;
        for (i = 0; i < 300; i++) begin
          res_stall <= 1'b1;
          @(posedge clk);
        end
      end else begin
        mode = $urandom_range(0, 2);
        seg  = $urandom_range(10, 80);
        for (i = 0; i < seg && !hold_ask; i++) begin
          case (mode)
            0:       res_stall <= 1'b0;
            1:       res_stall <= ($urandom_range(0, 99) < 30);
            default: res_stall <= ($urandom_range(0, 99) < 70);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  // Request side
  initial begin : request_side
    req_t r;
    int   phase_no;
    int   plen;
    int   k;
    int   j;
    int   blen;
    int   ins_pct;
    bit   quiet;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Empty list: every delete and a positional insert past the end
    send(mk(CMD_DEL_HEAD, 32'h1234_5678, 0));
    send(mk(CMD_DEL_TAIL, 32'h0, 31));
    send(mk(CMD_DEL_POS, 32'h0, 31));
    send(mk(CMD_INS_POS, 32'h0BAD_F00D, 1));
    // Extremes of value, head, tail, middle
    send(mk(CMD_INS_POS, 32'h8000_0000, 0));
    send(mk(CMD_INS_TAIL, 32'h7FFF_FFFF, 0));
    send(mk(CMD_INS_HEAD, 32'hFFFF_FFFF, 31));
    send(mk(CMD_INS_POS, 32'h0, 1));
    send(mk(CMD_DEL_POS, 32'h0, 4));
    send(mk(CMD_INS_POS, 32'h5A5A_5A5A, 4));
    // Fill to capacity
    repeat (11) send(mk(CMD_INS_TAIL, $urandom, $urandom_range(0, 31)));
    // Full list: rejects, with range checked before full, unknown codes, then deletes
    send(mk(CMD_INS_HEAD, 32'hA5A5_A5A5, 0));
    send(mk(CMD_INS_POS, 32'h1111_1111, 17));
    send(mk(CMD_INS_POS, 32'h2222_2222, 16));
    send(mk(3'd6, 32'hFFFF_FFFF, 31));
    send(mk(3'd7, 32'hFFFF_FFFF, 31));
    send(mk(CMD_DEL_POS, 32'h0, 16));
    send(mk(CMD_DEL_POS, 32'h0, 15));
    send(mk(CMD_DEL_TAIL, 32'h0, 0));
    send(mk(CMD_DEL_HEAD, 32'h0, 0));
    send(mk(CMD_DEL_POS, 32'h0, 7));
    drain();

    // Random phases: growing, shrinking and mixed, in bursts
    phase_no = 0;
    while (list_cmds < 550) begin
      plen = $urandom_range(20, 60);
      case ($urandom_range(0, 2))
        0:       ins_pct = 75;
        1:       ins_pct = 30;
        default: ins_pct = 50;
      endcase
      quiet = ($urandom_range(0, 3) == 0);
      if (phase_no == 2 || phase_no == 9) begin
        // long result hold-off while requests keep coming
        hold_ask <= 1'b1;
        for (j = 0; j < 24; j++) begin
          r = random_cmd(ins_pct);
          send(r);
          if (r.cmd <= CMD_DEL_POS) list_cmds++;
        end
      end
      if (phase_no == 5) drain();
      k = 0;
      while (k < plen) begin
        blen = $urandom_range(1, 12);
        for (j = 0; j < blen && k < plen; j++) begin
          r = random_cmd(ins_pct);
          send(r);
          k++;
          if (r.cmd <= CMD_DEL_POS) list_cmds++;
        end
        idle(quiet ? 0 : $urandom_range(0, 8));
      end
      phase_no++;
    end

    drain();
    repeat (40) @(posedge clk);
    if (failures == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
